// ===== rtl/core/ctqrm_pkg.sv =====
// ctqrm_pkg: shared codes, field layouts and handshake types for the CAN transmit queue
// with retry manager. No dependencies; used by every module under rtl/core.

package ctqrm_pkg;

    // event codes carried in the input tuser
    localparam logic [2:0] FUNC_ENQUEUE  = 3'd0;
    localparam logic [2:0] FUNC_TRANSMIT = 3'd1;
    localparam logic [2:0] FUNC_RECOVERY = 3'd2;
    localparam logic [2:0] FUNC_POLL     = 3'd3;
    localparam logic [2:0] FUNC_START    = 3'd4;

    // controller answers to a send attempt
    localparam logic [1:0] SEND_OK   = 2'd0;
    localparam logic [1:0] SEND_BUSY = 2'd1;

    // configuration register indexes
    localparam logic [1:0] REG_BUSY_RETRY_INTERVAL = 2'd0;
    localparam logic [1:0] REG_MAX_BUSY_RETRIES    = 2'd1;
    localparam logic [1:0] REG_RECOVERY_INTERVAL   = 2'd2;
    localparam logic [1:0] REG_POLL_INTERVAL       = 2'd3;

    // configuration reset values
    localparam logic [15:0] RST_BUSY_RETRY_INTERVAL = 16'd10;
    localparam logic [7:0]  RST_MAX_BUSY_RETRIES    = 8'd3;
    localparam logic [15:0] RST_RECOVERY_INTERVAL   = 16'd1000;
    localparam logic [15:0] RST_POLL_INTERVAL       = 16'd100;

    // diagnostic flag bit positions
    localparam int DIAG_NOT_READY   = 0;
    localparam int DIAG_FULL        = 1;
    localparam int DIAG_TX_BUSY     = 2;
    localparam int DIAG_TX_FAILED   = 3;
    localparam int DIAG_RX_OVERFLOW = 4;
    localparam int DIAG_BUS_OFF     = 5;
    localparam int DIAG_INIT_FAILED = 6;

    // widths of the stream words
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAME_W    = 40;

    // input tdata layout
    localparam int IN_NOW_LO    = 0;
    localparam int IN_SID_LO    = 32;
    localparam int IN_ADR_LO    = 48;
    localparam int IN_CMD_LO    = 56;
    localparam int IN_PAY_LO    = 64;
    localparam int IN_STATUS_LO = 72;
    localparam int IN_INIT_OK   = 74;
    localparam int IN_RX_OVF    = 75;
    localparam int IN_BUS_OFF   = 76;

    // output tdata layout
    localparam int OUT_ACCEPTED  = 0;
    localparam int OUT_DIAG_LO   = 1;
    localparam int OUT_SEND      = 8;
    localparam int OUT_ID_LO     = 9;
    localparam int OUT_ADR_LO    = 25;
    localparam int OUT_CMD_LO    = 33;
    localparam int OUT_PAY_LO    = 41;
    localparam int OUT_INIT_REQ  = 49;
    localparam int OUT_CLR_OVF   = 50;
    localparam int OUT_READY     = 51;
    localparam int OUT_LEVEL_LO  = 52;

    // controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the accepted transaction
        logic exec;    // apply the event and load the result register
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free; // result register empty or being drained this cycle
    } t_dp_status;

endpackage

// ===== rtl/core/ctqrm_ctrl.sv =====
// ctqrm_ctrl: sequencer for the CAN transmit queue; accepts one event, then schedules
// its execution once the result register can take it. Depends on ctqrm_pkg.

module ctqrm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ctqrm_pkg::t_dp_status i_status,
    output ctqrm_pkg::t_ctl_cmd   o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd.latch = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/ctqrm_datapath.sv =====
// ctqrm_datapath: frame ring store, queue pointers, timers, configuration registers and
// the result register of the CAN transmit queue. Depends on ctqrm_pkg.

module ctqrm_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ctqrm_pkg::t_ctl_cmd                    i_cmd,
    output ctqrm_pkg::t_dp_status                  o_status,
    input  logic [ctqrm_pkg::IN_DATA_W-1:0]        i_in_data,
    input  logic [ctqrm_pkg::IN_USER_W-1:0]        i_in_user,
    input  logic                                   i_cfg_valid,
    input  logic [ctqrm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ctqrm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [ctqrm_pkg::OUT_DATA_W-1:0]       o_out_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_fill_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // frame memory and its registered head read
    logic [ctqrm_pkg::FRAME_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ctqrm_pkg::FRAME_W-1:0] r_head_frame;

    // queue and timer state
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ready, n_ready;
    logic [31:0]      r_last_init, n_last_init;
    logic [31:0]      r_last_poll, n_last_poll;
    logic [7:0]       r_head_retries, n_head_retries;
    logic [31:0]      r_head_last, n_head_last;

    // configuration
    logic [15:0] r_busy_interval;
    logic [7:0]  r_max_retries;
    logic [15:0] r_recovery_interval;
    logic [15:0] r_poll_interval;

    // captured event
    logic [2:0]  r_func;
    logic [31:0] r_now;
    logic [ctqrm_pkg::FRAME_W-1:0] r_frame_in;
    logic [1:0]  r_send_status;
    logic        r_init_ok;
    logic        r_rx_ovf;
    logic        r_bus_off;

    // result register
    logic                            r_out_valid;
    logic [ctqrm_pkg::OUT_DATA_W-1:0] r_out_data;

    // event outcome
    logic        w_accepted;
    logic [6:0]  w_diag;
    logic        w_send;
    logic        w_init_req;
    logic        w_clr_ovf;
    logic        w_write;
    logic [31:0] w_then;
    logic [15:0] w_interval;
    logic [31:0] w_delta;
    logic        w_elapsed;
    logic [7:0]  w_retries_inc;
    logic        w_pop;
    logic [ctqrm_pkg::FRAME_W-1:0] w_sent;
    logic [CNT_W+3:0] w_level_ext;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_fill_count      = r_count;

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func        <= i_in_user;
            r_now         <= i_in_data[ctqrm_pkg::IN_NOW_LO +: 32];
            r_frame_in    <= {i_in_data[ctqrm_pkg::IN_SID_LO +: 16],
                              i_in_data[ctqrm_pkg::IN_ADR_LO +: 8],
                              i_in_data[ctqrm_pkg::IN_CMD_LO +: 8],
                              i_in_data[ctqrm_pkg::IN_PAY_LO +: 8]};
            r_send_status <= i_in_data[ctqrm_pkg::IN_STATUS_LO +: 2];
            r_init_ok     <= i_in_data[ctqrm_pkg::IN_INIT_OK];
            r_rx_ovf      <= i_in_data[ctqrm_pkg::IN_RX_OVF];
            r_bus_off     <= i_in_data[ctqrm_pkg::IN_BUS_OFF];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_interval     <= ctqrm_pkg::RST_BUSY_RETRY_INTERVAL;
            r_max_retries       <= ctqrm_pkg::RST_MAX_BUSY_RETRIES;
            r_recovery_interval <= ctqrm_pkg::RST_RECOVERY_INTERVAL;
            r_poll_interval     <= ctqrm_pkg::RST_POLL_INTERVAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ctqrm_pkg::REG_BUSY_RETRY_INTERVAL: r_busy_interval     <= i_cfg_data;
                ctqrm_pkg::REG_MAX_BUSY_RETRIES:    r_max_retries       <= i_cfg_data[7:0];
                ctqrm_pkg::REG_RECOVERY_INTERVAL:   r_recovery_interval <= i_cfg_data;
                ctqrm_pkg::REG_POLL_INTERVAL:       r_poll_interval     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // one shared elapsed-time check, operands chosen by event
    always_comb begin
        case (r_func)
            ctqrm_pkg::FUNC_TRANSMIT: begin
                w_then     = r_head_last;
                w_interval = r_busy_interval;
            end
            ctqrm_pkg::FUNC_RECOVERY: begin
                w_then     = r_last_init;
                w_interval = r_recovery_interval;
            end
            ctqrm_pkg::FUNC_POLL: begin
                w_then     = r_last_poll;
                w_interval = r_poll_interval;
            end
            default: begin
                w_then     = r_last_init;
                w_interval = 16'd0;
            end
        endcase
    end

    assign w_delta       = r_now - w_then;
    assign w_elapsed     = (w_delta >= {16'd0, w_interval});
    assign w_retries_inc = (r_head_retries != 8'hFF) ? (r_head_retries + 8'd1)
                                                     : r_head_retries;

    // event execution
    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_ready        = r_ready;
        n_last_init    = r_last_init;
        n_last_poll    = r_last_poll;
        n_head_retries = r_head_retries;
        n_head_last    = r_head_last;
        w_accepted     = 1'b0;
        w_diag         = 7'd0;
        w_send         = 1'b0;
        w_init_req     = 1'b0;
        w_clr_ovf      = 1'b0;
        w_write        = 1'b0;
        w_pop          = 1'b0;
        case (r_func)
            ctqrm_pkg::FUNC_ENQUEUE: begin
                if (!r_ready) begin
                    w_diag[ctqrm_pkg::DIAG_NOT_READY] = 1'b1;
                end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                    w_diag[ctqrm_pkg::DIAG_FULL] = 1'b1;
                end else begin
                    w_write    = 1'b1;
                    w_accepted = 1'b1;
                    n_tail     = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_tail + PTR_W'(1);
                    n_count    = r_count + CNT_W'(1);
                end
            end
            ctqrm_pkg::FUNC_TRANSMIT: begin
                if (r_ready && (r_count != '0) &&
                    ((r_head_retries == 8'd0) || w_elapsed)) begin
                    w_send      = 1'b1;
                    n_head_last = r_now;
                    if (r_send_status == ctqrm_pkg::SEND_OK) begin
                        w_pop = 1'b1;
                    end else if (r_send_status == ctqrm_pkg::SEND_BUSY) begin
                        n_head_retries                    = w_retries_inc;
                        w_diag[ctqrm_pkg::DIAG_TX_BUSY]   = 1'b1;
                        if (w_retries_inc >= r_max_retries) begin
                            w_diag[ctqrm_pkg::DIAG_TX_FAILED] = 1'b1;
                            w_pop                             = 1'b1;
                        end
                    end else begin
                        w_diag[ctqrm_pkg::DIAG_TX_FAILED] = 1'b1;
                        w_pop                             = 1'b1;
                    end
                    // popping hands fresh retry state to the next frame
                    if (w_pop) begin
                        n_head         = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : r_head + PTR_W'(1);
                        n_count        = r_count - CNT_W'(1);
                        n_head_retries = 8'd0;
                        n_head_last    = 32'd0;
                    end
                end
            end
            ctqrm_pkg::FUNC_RECOVERY: begin
                if (!r_ready && w_elapsed) begin
                    w_init_req  = 1'b1;
                    n_last_init = r_now;
                    n_ready     = r_init_ok;
                    w_diag[ctqrm_pkg::DIAG_INIT_FAILED] = !r_init_ok;
                end
            end
            ctqrm_pkg::FUNC_POLL: begin
                if (r_ready && w_elapsed) begin
                    n_last_poll = r_now;
                    if (r_rx_ovf) begin
                        w_diag[ctqrm_pkg::DIAG_RX_OVERFLOW] = 1'b1;
                        w_clr_ovf                           = 1'b1;
                    end
                    if (r_bus_off) begin
                        w_diag[ctqrm_pkg::DIAG_BUS_OFF] = 1'b1;
                        n_ready                         = 1'b0;
                        n_last_init                     = r_now;
                    end
                end
            end
            ctqrm_pkg::FUNC_START: begin
                w_init_req  = 1'b1;
                n_last_init = r_now;
                n_ready     = r_init_ok;
                w_diag[ctqrm_pkg::DIAG_INIT_FAILED] = !r_init_ok;
            end
            default: begin
            end
        endcase
    end

    assign w_sent      = w_send ? r_head_frame : '0;
    assign w_level_ext = (CNT_W + 4)'(n_count);

    // frame memory: one write port, registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_write) begin
            r_mem[r_tail] <= r_frame_in;
        end
        r_head_frame <= r_mem[r_head];
    end

    // queue and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_ready        <= 1'b0;
            r_last_init    <= 32'd0;
            r_last_poll    <= 32'd0;
            r_head_retries <= 8'd0;
            r_head_last    <= 32'd0;
        end else if (i_cmd.exec) begin
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_ready        <= n_ready;
            r_last_init    <= n_last_init;
            r_last_poll    <= n_last_poll;
            r_head_retries <= n_head_retries;
            r_head_last    <= n_head_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= {w_level_ext[3:0], n_ready, w_clr_ovf, w_init_req,
                           w_sent[7:0], w_sent[15:8], w_sent[23:16], w_sent[39:24],
                           w_send, w_diag, w_accepted};
        end
    end

endmodule

// ===== rtl/core/can_tx_queue_retry_manager.sv =====
// can_tx_queue_retry_manager: top level of the CAN transmit queue with busy retry,
// bus-off recovery and error polling. Depends on ctqrm_pkg, ctqrm_ctrl, ctqrm_datapath.
//
//  channel   direction  handshake                  contents
//  s_axis    in         i_s_axis_tvalid/o_..tready  one event: func in tuser, fields in tdata
//  m_axis    out        o_m_axis_tvalid/i_..tready  one result per event
//  cfg       in         i_cfg_valid/o_cfg_ready     register index and 16-bit value
//
// Each event is first accepted while the head frame is read from the frame memory, then
// applied once the result register can take it.
// A finished result waits in the output register while the next event is accepted; the
// execute step is held only while that register is still occupied.
// Reset (synchronous, active low) empties the queue, clears ready, zeroes timers and
// loads the register defaults. The frame memory needs no clearing.
// Configuration writes are taken in any cycle.

module can_tx_queue_retry_manager #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // now_ms, sender_id, addressee, command, payload, send_status, init_ok,
    // rx_overflow, bus_off, zero padding
    input  logic [ctqrm_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // func
    input  logic [ctqrm_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // accepted, diag_flags, send_valid, frame_id, frame_addressee, frame_command,
    // frame_payload, init_request, clear_overflow, ready_now, queue_level
    output logic [ctqrm_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ctqrm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ctqrm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ctqrm_pkg::t_ctl_cmd   w_cmd;
    ctqrm_pkg::t_dp_status w_status;
    logic [CNT_W-1:0]      w_fill_count;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ctqrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // queue, timers and result register
    ctqrm_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_in_data    (i_s_axis_tdata),
        .i_in_user    (i_s_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_data   (o_m_axis_tdata),
        .o_fill_count (w_fill_count)
    );

    // queue never holds more frames than it has room for
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill_count <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    // execution only when the result register can take the result
    a_exec_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> w_status.out_free)
        else $error("result overwritten before it was taken");

    // an accepted transaction is executed before the next one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second transaction taken while one is in progress");

    // no frame bytes reported without a send attempt
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[ctqrm_pkg::OUT_SEND]) |->
        (o_m_axis_tdata[ctqrm_pkg::OUT_PAY_LO+7:ctqrm_pkg::OUT_ID_LO] == '0))
        else $error("frame bytes present without send");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for can_tx_queue_retry_manager, with a clocked driver,
// a clocked monitor and an in-order predictor of the queue, retry and recovery logic.
// depends on ctqrm_pkg and the rtl under rtl/core

module testbench;

    localparam int DEPTH = 8;

    // codes the package does not name
    localparam logic [2:0] FUNC_SPARE    = 3'd5;
    localparam logic [2:0] FUNC_UNUSED   = 3'd7;
    localparam logic [1:0] SEND_FAIL     = 2'd2;
    localparam logic [1:0] SEND_RESERVED = 2'd3;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] now;
        logic [15:0] sid;
        logic [7:0]  adr;
        logic [7:0]  cmd;
        logic [7:0]  pay;
        logic [1:0]  status;
        logic        init_ok;
        logic        rx_ovf;
        logic        bus_off;
    } t_can_event;

    // laid out as the result tdata, top field first
    typedef struct packed {
        logic [3:0]  level;
        logic        ready;
        logic        clr_ovf;
        logic        init_req;
        logic [7:0]  pay;
        logic [7:0]  cmd;
        logic [7:0]  adr;
        logic [15:0] id;
        logic        send;
        logic [6:0]  diag;
        logic        accepted;
    } t_can_outcome;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    // now_ms, sender_id, addressee, command, payload, send_status, init_ok,
    // rx_overflow, bus_off, zero padding
    logic [ctqrm_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // func
    logic [ctqrm_pkg::IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    // accepted, diag_flags, send_valid, frame_id, frame_addressee, frame_command,
    // frame_payload, init_request, clear_overflow, ready_now, queue_level
    logic [ctqrm_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [ctqrm_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ctqrm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    can_tx_queue_retry_manager #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // stimulus and expectation stores
    t_can_event   pending_events[$];
    t_can_outcome awaited_outcomes[$];
    t_can_event   offered_event;
    bit           event_held = 1'b0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic [31:0]  seq_ms = '0;

    // statistics
    int errors = 0;
    int events_applied = 0;
    int outcomes_checked = 0;
    int frames_sent = 0;
    int frames_queued = 0;
    int init_attempts = 0;
    int cfg_writes = 0;

    // predicted block state
    logic [39:0] frame_mem [DEPTH];
    int          rd_idx = 0;
    int          wr_idx = 0;
    int          frames_held = 0;
    logic        link_ready = 1'b0;
    logic [31:0] last_init_ms = '0;
    logic [31:0] last_poll_ms = '0;
    logic [7:0]  head_tries = '0;
    logic [31:0] head_tried_ms = '0;

    // predicted register contents
    logic [15:0] busy_gap_ms = ctqrm_pkg::RST_BUSY_RETRY_INTERVAL;
    logic [7:0]  retry_limit = ctqrm_pkg::RST_MAX_BUSY_RETRIES;
    logic [15:0] recovery_gap_ms = ctqrm_pkg::RST_RECOVERY_INTERVAL;
    logic [15:0] poll_gap_ms = ctqrm_pkg::RST_POLL_INTERVAL;

    // wrapping elapsed-time test
    function automatic logic interval_passed(input logic [31:0] now_ms, then_ms,
                                             input logic [15:0] gap_ms);
        logic [31:0] diff;
        diff = now_ms - then_ms;
        return diff >= {16'd0, gap_ms};
    endfunction

    // apply one event to the predicted state and return its result
    function automatic t_can_outcome service_event(input t_can_event ev);
        t_can_outcome r;
        r = '0;
        case (ev.func)
            ctqrm_pkg::FUNC_ENQUEUE: begin
                if (!link_ready) begin
                    r.diag[ctqrm_pkg::DIAG_NOT_READY] = 1'b1;
                end else if (frames_held >= DEPTH) begin
                    r.diag[ctqrm_pkg::DIAG_FULL] = 1'b1;
                end else begin
                    frame_mem[wr_idx] = {ev.sid, ev.adr, ev.cmd, ev.pay};
                    wr_idx = (wr_idx + 1) % DEPTH;
                    frames_held++;
                    r.accepted = 1'b1;
                end
            end
            ctqrm_pkg::FUNC_TRANSMIT: begin
                if (link_ready && frames_held != 0 && (head_tries == 0 ||
                        interval_passed(ev.now, head_tried_ms, busy_gap_ms))) begin
                    r.send = 1'b1;
                    {r.id, r.adr, r.cmd, r.pay} = frame_mem[rd_idx];
                    head_tried_ms = ev.now;
                    if (ev.status == ctqrm_pkg::SEND_BUSY) begin
                        if (head_tries != 8'hFF) head_tries++;
                        r.diag[ctqrm_pkg::DIAG_TX_BUSY] = 1'b1;
                    end
                    // busy below the limit keeps the frame, anything else but ok fails it
                    if (ev.status != ctqrm_pkg::SEND_OK &&
                            (ev.status != ctqrm_pkg::SEND_BUSY ||
                             head_tries >= retry_limit)) begin
                        r.diag[ctqrm_pkg::DIAG_TX_FAILED] = 1'b1;
                    end
                    if (ev.status == ctqrm_pkg::SEND_OK ||
                            r.diag[ctqrm_pkg::DIAG_TX_FAILED]) begin
                        rd_idx = (rd_idx + 1) % DEPTH;
                        frames_held--;
                        head_tries = '0;
                        head_tried_ms = '0;
                    end
                end
            end
            ctqrm_pkg::FUNC_RECOVERY, ctqrm_pkg::FUNC_START: begin
                // start always initialises, recovery only when down and due
                if (ev.func == ctqrm_pkg::FUNC_START || (!link_ready &&
                        interval_passed(ev.now, last_init_ms, recovery_gap_ms))) begin
                    r.init_req = 1'b1;
                    last_init_ms = ev.now;
                    link_ready = ev.init_ok;
                    r.diag[ctqrm_pkg::DIAG_INIT_FAILED] = !ev.init_ok;
                end
            end
            ctqrm_pkg::FUNC_POLL: begin
                if (link_ready && interval_passed(ev.now, last_poll_ms, poll_gap_ms)) begin
                    last_poll_ms = ev.now;
                    if (ev.rx_ovf) begin
                        r.diag[ctqrm_pkg::DIAG_RX_OVERFLOW] = 1'b1;
                        r.clr_ovf = 1'b1;
                    end
                    if (ev.bus_off) begin
                        r.diag[ctqrm_pkg::DIAG_BUS_OFF] = 1'b1;
                        link_ready = 1'b0;
                        last_init_ms = ev.now;
                    end
                end
            end
            default: begin
            end
        endcase
        r.ready = link_ready;
        r.level = 4'(frames_held);
        return r;
    endfunction

    // random event on a running millisecond clock, biased to fill or drain the queue
    function automatic t_can_event random_event(input bit fill_bias);
        t_can_event ev;
        int pick;
        int step;
        ev.sid = 16'($urandom);
        ev.adr = 8'($urandom);
        ev.cmd = 8'($urandom);
        ev.pay = 8'($urandom);
        ev.status = 2'($urandom);
        ev.init_ok = 1'($urandom);
        ev.rx_ovf = 1'($urandom);
        ev.bus_off = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < (fill_bias ? 55 : 25)) ev.func = ctqrm_pkg::FUNC_ENQUEUE;
        else if (pick < 75) ev.func = ctqrm_pkg::FUNC_TRANSMIT;
        else if (pick < 83) ev.func = ctqrm_pkg::FUNC_RECOVERY;
        else if (pick < 92) ev.func = ctqrm_pkg::FUNC_POLL;
        else if (pick < 97) ev.func = ctqrm_pkg::FUNC_START;
        else ev.func = 3'($urandom_range(FUNC_SPARE, FUNC_UNUSED));
        // mostly short steps around the intervals, now and then a long jump
        pick = $urandom_range(99);
        if (pick < 45) step = $urandom_range(12);
        else if (pick < 80) step = $urandom_range(150);
        else if (pick < 95) step = $urandom_range(1500);
        else step = $urandom_range(100000);
        seq_ms += 32'(step);
        ev.now = seq_ms;
        case (ev.func)
            ctqrm_pkg::FUNC_TRANSMIT: begin
                pick = $urandom_range(99);
                if (pick < 50) ev.status = ctqrm_pkg::SEND_OK;
                else if (pick < 85) ev.status = ctqrm_pkg::SEND_BUSY;
                else if (pick < 95) ev.status = SEND_FAIL;
                else ev.status = SEND_RESERVED;
            end
            ctqrm_pkg::FUNC_RECOVERY, ctqrm_pkg::FUNC_START:
                ev.init_ok = ($urandom_range(99) < 80);
            ctqrm_pkg::FUNC_POLL: begin
                ev.rx_ovf = ($urandom_range(99) < 40);
                ev.bus_off = ($urandom_range(99) < 6);
            end
            default: begin
            end
        endcase
        // occasional noise: any code at any time
        if ($urandom_range(99) < 4) begin
            ev.now = $urandom;
            ev.func = 3'($urandom);
        end
        return ev;
    endfunction

    task automatic queue_event(input logic [2:0] func, input logic [31:0] now_ms,
                               input logic [39:0] frame, input logic [1:0] status,
                               input logic [2:0] flags);
        t_can_event ev;
        ev.func = func;
        ev.now = now_ms;
        {ev.sid, ev.adr, ev.cmd, ev.pay} = frame;
        ev.status = status;
        {ev.bus_off, ev.rx_ovf, ev.init_ok} = flags;
        pending_events.push_back(ev);
    endtask

    task automatic wait_drained;
        while (pending_events.size() != 0 || event_held || awaited_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // one register write transaction, mirrored into the predictor once taken
    task automatic write_reg(input logic [ctqrm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            ctqrm_pkg::REG_BUSY_RETRY_INTERVAL: busy_gap_ms = value;
            ctqrm_pkg::REG_MAX_BUSY_RETRIES:    retry_limit = value[7:0];
            ctqrm_pkg::REG_RECOVERY_INTERVAL:   recovery_gap_ms = value;
            ctqrm_pkg::REG_POLL_INTERVAL:       poll_gap_ms = value;
            default: begin
            end
        endcase
        cfg_writes++;
    endtask

    task automatic program_timing(input logic [15:0] busy_gap, input logic [7:0] tries,
                                  input logic [15:0] recovery_gap, input logic [15:0] poll_gap);
        write_reg(ctqrm_pkg::REG_BUSY_RETRY_INTERVAL, busy_gap);
        // upper byte of the retry limit write is junk and must be ignored
        write_reg(ctqrm_pkg::REG_MAX_BUSY_RETRIES, {8'($urandom), tries});
        write_reg(ctqrm_pkg::REG_RECOVERY_INTERVAL, recovery_gap);
        write_reg(ctqrm_pkg::REG_POLL_INTERVAL, poll_gap);
    endtask

    task automatic run_phase(input int count, input int send_idle, input int recv_idle);
        int burst;
        bit fill_bias;
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        burst = 0;
        fill_bias = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                fill_bias = 1'($urandom);
                burst = $urandom_range(5, 30);
            end
            burst--;
            pending_events.push_back(random_event(fill_bias));
        end
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v, got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                     $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // driver: offers pending events, predicts each one as its transaction completes
    always @(posedge i_clk) begin : drive_proc
        logic next_valid;
        if (i_rst_n) begin
            next_valid = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                awaited_outcomes.push_back(service_event(offered_event));
                events_applied++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_events.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                offered_event = pending_events.pop_front();
                next_valid = 1'b1;
                i_s_axis_tdata <= {3'b000, offered_event.bus_off, offered_event.rx_ovf,
                                   offered_event.init_ok, offered_event.status,
                                   offered_event.pay, offered_event.cmd, offered_event.adr,
                                   offered_event.sid, offered_event.now};
                i_s_axis_tuser <= offered_event.func;
            end
            event_held = next_valid;
            i_s_axis_tvalid <= next_valid;
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge i_clk) begin : watch_proc
        t_can_outcome got;
        t_can_outcome want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: result with nothing expected, actual 'h%0h",
                             $time, o_m_axis_tdata);
                    errors++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("accepted", 16'(want.accepted), 16'(got.accepted));
                    check_field("diag_flags", 16'(want.diag), 16'(got.diag));
                    check_field("send_valid", 16'(want.send), 16'(got.send));
                    check_field("frame_id", want.id, got.id);
                    check_field("frame_addressee", 16'(want.adr), 16'(got.adr));
                    check_field("frame_command", 16'(want.cmd), 16'(got.cmd));
                    check_field("frame_payload", 16'(want.pay), 16'(got.pay));
                    check_field("init_request", 16'(want.init_req), 16'(got.init_req));
                    check_field("clear_overflow", 16'(want.clr_ovf), 16'(got.clr_ovf));
                    check_field("ready_now", 16'(want.ready), 16'(got.ready));
                    check_field("queue_level", 16'(want.level), 16'(got.level));
                    outcomes_checked++;
                    frames_sent += int'(want.send);
                    frames_queued += int'(want.accepted);
                    init_attempts += int'(want.init_req);
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // sequence of phases
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed events on the reset register values
        send_idle_pct = 21;
        recv_idle_pct = 64;
        // not ready
        queue_event(ctqrm_pkg::FUNC_ENQUEUE, 32'd0, 40'hFF_FFFF_FFFF,
                    ctqrm_pkg::SEND_OK, 3'b000);
        // not ready
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd0, '0, ctqrm_pkg::SEND_OK, 3'b000);
        // too early
        queue_event(ctqrm_pkg::FUNC_RECOVERY, 32'd999, '0, ctqrm_pkg::SEND_OK, 3'b001);
        // init fails
        queue_event(ctqrm_pkg::FUNC_START, 32'd5, '0, ctqrm_pkg::SEND_OK, 3'b000);
        // comes up
        queue_event(ctqrm_pkg::FUNC_RECOVERY, 32'd1005, '0, ctqrm_pkg::SEND_OK, 3'b001);
        // already up
        queue_event(ctqrm_pkg::FUNC_RECOVERY, 32'd3000, '0, ctqrm_pkg::SEND_OK, 3'b001);
        // empty
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3001, '0, ctqrm_pkg::SEND_OK, 3'b000);
        // fill to the brim, then one more
        for (int n = 0; n <= DEPTH; n++) begin
            queue_event(ctqrm_pkg::FUNC_ENQUEUE, 32'd3002 + n,
                        (n == 0) ? 40'hFF_FFFF_FFFF :
                        (n == 1) ? 40'h00_0000_0000 : {$urandom, 8'($urandom)},
                        ctqrm_pkg::SEND_OK, 3'b000);
        end
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3100, '0, ctqrm_pkg::SEND_OK, 3'b000);
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3200, '0, ctqrm_pkg::SEND_BUSY, 3'b000);
        // retry too soon
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3209, '0, ctqrm_pkg::SEND_OK, 3'b000);
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3210, '0, ctqrm_pkg::SEND_BUSY, 3'b000);
        // limit reached
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3220, '0, ctqrm_pkg::SEND_BUSY, 3'b000);
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3230, '0, SEND_FAIL, 3'b000);
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'd3240, '0, SEND_RESERVED, 3'b000);
        // overflow, bus off
        queue_event(ctqrm_pkg::FUNC_POLL, 32'd3300, '0, ctqrm_pkg::SEND_OK, 3'b110);
        // down, ignored
        queue_event(ctqrm_pkg::FUNC_POLL, 32'd3500, '0, ctqrm_pkg::SEND_OK, 3'b110);
        queue_event(FUNC_SPARE, 32'd3600, 40'hFF_FFFF_FFFF, SEND_RESERVED, 3'b111);
        queue_event(FUNC_UNUSED, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, SEND_RESERVED, 3'b111);
        queue_event(ctqrm_pkg::FUNC_START, 32'hFFFF_FFF0, '0, ctqrm_pkg::SEND_OK, 3'b001);
        // busy retry across the wrap of the millisecond counter
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'hFFFF_FFFA, '0,
                    ctqrm_pkg::SEND_BUSY, 3'b000);
        queue_event(ctqrm_pkg::FUNC_TRANSMIT, 32'h0000_0004, '0,
                    ctqrm_pkg::SEND_OK, 3'b000);
        wait_drained();

        program_timing(16'd5, 8'd2, 16'd50, 16'd20);
        run_phase(350, 21, 64);

        // smallest intervals, clock close to its wrap
        program_timing(16'd0, 8'd1, 16'd0, 16'd0);
        seq_ms = 32'hFFFF_8000;
        run_phase(350, 64, 21);

        program_timing(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        run_phase(350, 64, 21);

        // a retry limit of zero drops on the first busy answer
        program_timing(16'd3, 8'd0, 16'd200, 16'd7);
        run_phase(350, 0, 0);

        repeat (4) @(posedge i_clk);
        $display("%0d events applied and %0d results checked over five phases, %0d reg writes",
                 events_applied, outcomes_checked, cfg_writes);
        $display("%0d frames queued, %0d send attempts, %0d controller initialisations",
                 frames_queued, frames_sent, init_attempts);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ctqrm_pkg.sv
rtl/core/ctqrm_ctrl.sv
rtl/core/ctqrm_datapath.sv
rtl/core/can_tx_queue_retry_manager.sv
tb/sv/testbench.sv
